[hw/rtl/dda_pkg.sv]
`timescale 1ns / 1ps
// Package for the decimal digit accumulator: sizes, operation codes and the microcode table.
package dda_pkg;

    localparam int DIGITS    = 6;
    localparam int DIGIT_W   = 4;
    localparam int STORE_W   = DIGITS * DIGIT_W;
    localparam int VALUE_W   = 24;
    localparam int PACKED_W  = 24;
    localparam int CONTENT_W = 20;
    localparam int CNT_W     = $clog2(VALUE_W);
    localparam int PC_W      = 3;
    localparam logic [DIGIT_W-1:0] RADIX = 4'd10;

    // Input mode codes.
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_SET = 2'd2;

    // Effective digit operation, settled when the transaction is taken.
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_SET  = 2'd2,
        OP_HOLD = 2'd3
    } digit_op_t;

    // Datapath action of one microcode step.
    typedef enum logic [2:0] {
        ACT_WAIT_IN = 3'd0,
        ACT_DABBLE  = 3'd1,
        ACT_DIGIT   = 3'd2,
        ACT_ACCUM   = 3'd3,
        ACT_EMIT    = 3'd4
    } action_t;

    // Sequencing of one microcode step.
    typedef enum logic [2:0] {
        JMP_WAIT_IN  = 3'd0,  // stay until an input transaction is taken
        JMP_LOOP_BIT = 3'd1,  // stay until the last operand bit
        JMP_LOOP_DIG = 3'd2,  // stay until the last digit
        JMP_WAIT_OUT = 3'd3,  // stay while the output register is occupied
        JMP_NEXT     = 3'd4
    } jump_t;

    typedef struct packed {
        action_t          act;
        jump_t            jmp;
        logic [PC_W-1:0]  target;
    } uword_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic dabble;
        logic digit;
        logic accum;
    } dp_ctrl_t;

    localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
    localparam logic [PC_W-1:0] PC_DABBLE = 3'd1;
    localparam logic [PC_W-1:0] PC_DIGIT  = 3'd2;
    localparam logic [PC_W-1:0] PC_ACCUM  = 3'd3;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd4;

    // The control store. Loop steps fall through to the next address when done.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_IDLE:   w = '{act: ACT_WAIT_IN, jmp: JMP_WAIT_IN,  target: PC_DABBLE};
            PC_DABBLE: w = '{act: ACT_DABBLE,  jmp: JMP_LOOP_BIT, target: PC_DIGIT};
            PC_DIGIT:  w = '{act: ACT_DIGIT,   jmp: JMP_LOOP_DIG, target: PC_ACCUM};
            PC_ACCUM:  w = '{act: ACT_ACCUM,   jmp: JMP_LOOP_DIG, target: PC_EMIT};
            PC_EMIT:   w = '{act: ACT_EMIT,    jmp: JMP_WAIT_OUT, target: PC_IDLE};
            default:   w = '{act: ACT_WAIT_IN, jmp: JMP_NEXT,     target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/dda_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the decimal digit accumulator: digit store, operand converter and content accumulator.
module dda_datapath
    import dda_pkg::*;
(
    input  logic                 aclk,
    input  dp_ctrl_t             ctrl,
    input  logic [1:0]           in_mode,
    input  logic [VALUE_W-1:0]   in_value,
    input  logic                 aresetn,
    output logic [STORE_W-1:0]   store,
    output logic [CONTENT_W-1:0] content
);

    logic [STORE_W-1:0]   store_reg, store_next;
    logic [STORE_W-1:0]   conv_reg, conv_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [CONTENT_W-1:0] acc_reg, acc_next;
    digit_op_t            op_reg, op_next;
    logic                 carry_reg, carry_next;

    logic [STORE_W-1:0]   conv_adj;
    logic [DIGIT_W-1:0]   cur_digit;
    logic [DIGIT_W-1:0]   opd_digit;
    logic [DIGIT_W-1:0]   top_digit;
    logic [DIGIT_W-1:0]   new_digit;
    logic                 new_carry;
    logic [DIGIT_W:0]     sum;
    logic [DIGIT_W:0]     take;

    assign cur_digit = store_reg[DIGIT_W-1:0];
    assign opd_digit = conv_reg[DIGIT_W-1:0];
    assign top_digit = store_reg[STORE_W-1 -: DIGIT_W];
    assign sum  = {1'b0, cur_digit} + {1'b0, opd_digit} + {{DIGIT_W{1'b0}}, carry_reg};
    assign take = {1'b0, opd_digit} + {{DIGIT_W{1'b0}}, carry_reg};

    // Add-three correction ahead of each doubling of the converter.
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            if (conv_reg[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                conv_adj[k*DIGIT_W +: DIGIT_W] = conv_reg[k*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                conv_adj[k*DIGIT_W +: DIGIT_W] = conv_reg[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // One decimal digit of the selected operation, least significant first.
    always_comb begin
        new_digit = cur_digit;
        new_carry = 1'b0;
        unique case (op_reg)
            OP_ADD: begin
                if (sum >= {1'b0, RADIX}) begin
                    new_digit = DIGIT_W'(sum - {1'b0, RADIX});
                    new_carry = 1'b1;
                end else begin
                    new_digit = sum[DIGIT_W-1:0];
                end
            end
            OP_SUB: begin
                if ({1'b0, cur_digit} >= take) begin
                    new_digit = DIGIT_W'({1'b0, cur_digit} - take);
                end else begin
                    new_digit = DIGIT_W'({1'b0, cur_digit} + {1'b0, RADIX} - take);
                    new_carry = 1'b1;
                end
            end
            OP_SET: begin
                new_digit = opd_digit;
            end
            OP_HOLD: begin
                new_digit = cur_digit;
            end
        endcase
    end

    always_comb begin
        store_next = store_reg;
        conv_next  = conv_reg;
        val_next   = val_reg;
        acc_next   = acc_reg;
        op_next    = op_reg;
        carry_next = carry_reg;
        if (ctrl.load) begin
            val_next   = in_value;
            conv_next  = '0;
            acc_next   = '0;
            carry_next = 1'b0;
            unique case (in_mode)
                MODE_ADD: op_next = OP_ADD;
                MODE_SUB: op_next = (store_reg == '0) ? OP_HOLD : OP_SUB;
                MODE_SET: op_next = OP_SET;
                default:  op_next = OP_HOLD;
            endcase
        end
        if (ctrl.dabble) begin
            conv_next = {conv_adj[STORE_W-2:0], val_reg[VALUE_W-1]};
            val_next  = {val_reg[VALUE_W-2:0], 1'b0};
        end
        if (ctrl.digit) begin
            // Rotate the store right by one digit; after DIGITS steps it is back in place.
            store_next = (store_reg >> DIGIT_W)
                       | (STORE_W'(new_digit) << (STORE_W - DIGIT_W));
            conv_next  = conv_reg >> DIGIT_W;
            carry_next = new_carry;
        end
        if (ctrl.accum) begin
            // Horner evaluation from the most significant digit, rotating left.
            store_next = (store_reg << DIGIT_W) | STORE_W'(top_digit);
            acc_next   = (acc_reg << 3) + (acc_reg << 1) + CONTENT_W'(top_digit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg <= '0;
            op_reg    <= OP_HOLD;
        end else begin
            store_reg <= store_next;
            op_reg    <= op_next;
        end
        conv_reg  <= conv_next;
        val_reg   <= val_next;
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
    end

    assign store   = store_reg;
    assign content = acc_reg;

endmodule

[hw/rtl/decimal_digit_accumulator.sv]
`timescale 1ns / 1ps
// Top level of the decimal digit accumulator: microcode sequencer and output register.
//
// The block keeps a row of DIGITS decimal digits. Each input transaction on the
// s_ channel carries a mode (add, subtract, set) and a 24-bit binary value. The
// value is converted to decimal with one shift-and-correct step per operand bit,
// then applied one digit per cycle with decimal carry or borrow, wrapping modulo
// ten to the power of DIGITS. Subtract leaves a zero row untouched, and the
// unused mode only reports the row. Every input transaction yields one result
// transaction on the m_ channel with the BCD digits and their binary value.
//
// After the input is taken, the sequencer runs 24 conversion steps, 6 digit steps,
// 6 accumulation steps and one step that loads the output register, and it takes
// the next input only after that last step; the 24-step operand conversion makes
// up most of the work for each item.
//
// Reset clears the digits to zero, empties the output register and puts the
// sequencer at its idle step, ready for input. When the receiver stalls, the
// output register holds its result and the sequencer runs the next item up to
// its last step, where it waits for the register to empty.
module decimal_digit_accumulator
    import dda_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [VALUE_W-1:0]   s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PACKED_W-1:0]  m_packed_digits,
    output logic [CONTENT_W-1:0] m_binary_content
);

    logic [PC_W-1:0]      pc_reg, pc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [PACKED_W-1:0]  m_packed_reg, m_packed_next;
    logic [CONTENT_W-1:0] m_content_reg, m_content_next;

    uword_t               uw;
    dp_ctrl_t             ctrl;
    logic                 out_busy;
    logic                 accept_in;
    logic                 emit;
    logic                 bit_last;
    logic                 dig_last;
    logic [STORE_W-1:0]   store;
    logic [CONTENT_W-1:0] content;
    logic [31:0]          packed_wide;

    // Fetch the control word of the current step.
    assign uw = ucode(pc_reg);

    assign out_busy  = m_valid_reg && !m_ready;
    assign accept_in = (uw.act == ACT_WAIT_IN) && s_valid;
    assign emit      = (uw.act == ACT_EMIT) && !out_busy;
    assign bit_last  = (cnt_reg == CNT_W'(VALUE_W - 1));
    assign dig_last  = (cnt_reg == CNT_W'(DIGITS - 1));

    assign ctrl.load   = accept_in;
    assign ctrl.dabble = (uw.act == ACT_DABBLE);
    assign ctrl.digit  = (uw.act == ACT_DIGIT);
    assign ctrl.accum  = (uw.act == ACT_ACCUM);

    // Step counter and conditional jumps. Loops clear the counter as they exit.
    always_comb begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        unique case (uw.jmp)
            JMP_WAIT_IN: begin
                cnt_next = '0;
                if (s_valid) begin
                    pc_next = uw.target;
                end
            end
            JMP_LOOP_BIT: begin
                if (bit_last) begin
                    pc_next  = uw.target;
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            JMP_LOOP_DIG: begin
                if (dig_last) begin
                    pc_next  = uw.target;
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            JMP_WAIT_OUT: begin
                if (!out_busy) begin
                    pc_next = uw.target;
                end
            end
            JMP_NEXT: begin
                pc_next = uw.target;
            end
            default: begin
                pc_next = PC_IDLE;
            end
        endcase
    end

    // The digit row widened to the largest row and trimmed to the port width.
    always_comb begin
        packed_wide = '0;
        packed_wide[STORE_W-1:0] = store;
    end

    // Output register, loaded by the final step once it is free.
    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_packed_next  = m_packed_reg;
        m_content_next = m_content_reg;
        if (emit) begin
            m_valid_next   = 1'b1;
            m_packed_next  = packed_wide[PACKED_W-1:0];
            m_content_next = content;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PC_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        m_packed_reg  <= m_packed_next;
        m_content_reg <= m_content_next;
    end

    dda_datapath u_datapath (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .in_mode  (s_mode),
        .in_value (s_value),
        .aresetn  (aresetn),
        .store    (store),
        .content  (content)
    );

    assign s_ready          = (uw.act == ACT_WAIT_IN);
    assign m_valid          = m_valid_reg;
    assign m_packed_digits  = m_packed_reg;
    assign m_binary_content = m_content_reg;

endmodule

[hw/rtl/dda_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the decimal digit accumulator and its bind statement.
module dda_checker
    import dda_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [PACKED_W-1:0]  m_packed_digits,
    input logic [CONTENT_W-1:0] m_binary_content
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_digits)
                                && $stable(m_binary_content))
        else $error("result changed while stalled");

    // A taken input starts a multi-cycle sequence, so the block is busy next cycle.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // Every reported nibble is a decimal digit.
    a_bcd_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_packed_digits[3:0] <= 4'd9 && m_packed_digits[7:4] <= 4'd9
                 && m_packed_digits[11:8] <= 4'd9 && m_packed_digits[15:12] <= 4'd9
                 && m_packed_digits[19:16] <= 4'd9 && m_packed_digits[23:20] <= 4'd9)
        else $error("result digit out of decimal range");

    // After reset the output is empty and the input side is open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("wrong state after reset");

endmodule

bind decimal_digit_accumulator dda_checker u_dda_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_packed_digits  (m_packed_digits),
    .m_binary_content (m_binary_content)
);

[sim/decimal_digit_accumulator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the decimal digit accumulator with random handshake timing.
module decimal_digit_accumulator_tb;
    import dda_pkg::*;

    // The fourth mode code has no operation; the block only reports the row.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int CLK_HALF      = 1;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 450;
    localparam int QUIET_TAIL    = 60;      // transactions at the end with no idling
    localparam int DRAIN_AT      = 240;     // queue position where the sender waits to drain
    localparam int HOLD_AT       = 120;     // results seen before the long receiver hold
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 60;      // wait for any stray result after the last expected one
    localparam int LIMIT_CYCLES  = 200000;
    localparam int MAX_REPORTS   = 10;

    // One pending input transaction. When wait_drain is set, the sender holds the
    // transaction back until every result issued so far has been received.
    typedef struct {
        logic [1:0]         mode;
        logic [VALUE_W-1:0] value;
        bit                 wait_drain;
    } row_op_t;

    // The row as the block must report it after one operation.
    typedef struct {
        logic [PACKED_W-1:0]  bcd;
        logic [CONTENT_W-1:0] content;
    } row_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_mode = MODE_ADD;
    logic [VALUE_W-1:0]   s_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PACKED_W-1:0]  m_packed_digits;
    logic [CONTENT_W-1:0] m_binary_content;

    row_op_t     pending_ops[$];
    row_result_t expected_rows[$];

    // The testbench's own copy of the digit row, least significant digit at index 0.
    logic [DIGIT_W-1:0] row_digits [DIGITS];

    int issued_cnt  = 0;   // transactions taken by the block, updated by the driver only
    int retired_cnt = 0;   // results received, updated by the monitor only
    int cycle_cnt   = 0;
    int err_cnt     = 0;
    int total_items = 0;

    decimal_digit_accumulator u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packed_digits  (m_packed_digits),
        .m_binary_content (m_binary_content)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Applies one operation to the row copy and returns what the block must report.
    // Both add and subtract walk the digits from the least significant one, so only
    // the low DIGITS decimal digits of the operand ever take part.
    function automatic row_result_t apply_to_row(input logic [1:0] mode,
                                                 input logic [VALUE_W-1:0] value);
        int unsigned operand;
        int unsigned carry;
        int unsigned sum;
        int unsigned take;
        int unsigned content;
        row_result_t res;
        operand = value;
        carry   = 0;
        content = 0;
        for (int k = DIGITS - 1; k >= 0; k--) begin
            content = content * RADIX + row_digits[k];
        end
        case (mode)
            MODE_ADD: begin
                for (int k = 0; k < DIGITS; k++) begin
                    sum = row_digits[k] + carry + operand % RADIX;
                    operand = operand / RADIX;
                    carry = sum / RADIX;
                    row_digits[k] = DIGIT_W'(sum % RADIX);
                end
            end
            MODE_SUB: begin
                // A row of zeros is left alone; otherwise borrow wraps past zero.
                if (content != 0) begin
                    for (int k = 0; k < DIGITS; k++) begin
                        take = carry + operand % RADIX;
                        operand = operand / RADIX;
                        if (row_digits[k] >= take) begin
                            row_digits[k] = DIGIT_W'(row_digits[k] - take);
                            carry = 0;
                        end else begin
                            row_digits[k] = DIGIT_W'(row_digits[k] + RADIX - take);
                            carry = 1;
                        end
                    end
                end
            end
            MODE_SET: begin
                for (int k = 0; k < DIGITS; k++) begin
                    row_digits[k] = DIGIT_W'(operand % RADIX);
                    operand = operand / RADIX;
                end
            end
            default: begin
            end
        endcase
        res.bcd = '0;
        content = 0;
        for (int k = DIGITS - 1; k >= 0; k--) begin
            content = content * RADIX + row_digits[k];
            res.bcd[DIGIT_W*k +: DIGIT_W] = row_digits[k];
        end
        res.content = CONTENT_W'(content);
        return res;
    endfunction

    // Queues one input transaction; the transaction at DRAIN_AT waits for a full drain.
    task automatic queue_op(input logic [1:0] mode, input logic [VALUE_W-1:0] value);
        row_op_t op;
        op.mode       = mode;
        op.value      = value;
        op.wait_drain = (pending_ops.size() == DRAIN_AT);
        pending_ops.push_back(op);
    endtask

    // Operands are spread over small counts, six-digit numbers, the full 24-bit
    // range and the edges where wrapping and wide operands show up.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = VALUE_W'($urandom_range(0, 99));
            1: v = VALUE_W'($urandom_range(0, 999999));
            2: v = VALUE_W'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = '1;
                    2: v = VALUE_W'(999999);
                    3: v = VALUE_W'(1000000);
                    default: v = VALUE_W'(1);
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_mode();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 8) begin
            return MODE_ADD;
        end else if (roll < 15) begin
            return MODE_SUB;
        end else if (roll < 19) begin
            return MODE_SET;
        end
        return MODE_UNUSED;
    endfunction

    // Idling is allowed in three of every four windows of cycle_cnt, which leaves
    // stretches of full-rate traffic, and never near the end of the run.
    function automatic bit idling_allowed(input int done_cnt);
        return (done_cnt + QUIET_TAIL < total_items) && ((cycle_cnt / 64) % 4 != 3);
    endfunction

    // Driver: presents the head of pending_ops. Valid stays up with a stable payload
    // until the transaction is taken; the expected row is predicted at that edge.
    // After a taken transaction the sender may idle for a random gap before the next one.
    always @(posedge aclk) begin : driver
        bit presenting;
        int gap_left;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            presenting = s_valid;
            if (s_valid && s_ready) begin
                expected_rows.push_back(apply_to_row(s_mode, s_value));
                void'(pending_ops.pop_front());
                issued_cnt <= issued_cnt + 1;
                presenting = 1'b0;
                if (idling_allowed(issued_cnt) && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 3);
                end
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() > 0) begin
                    // A drain point holds the sender until every expected result is back.
                    if (!pending_ops[0].wait_drain || expected_rows.size() == 0) begin
                        s_mode     <= pending_ops[0].mode;
                        s_value    <= pending_ops[0].value;
                        presenting = 1'b1;
                    end
                end
            end
            s_valid <= presenting;
        end
    end

    // Monitor: checks each result transaction against the oldest expected row and
    // drives m_ready. Besides short stall bursts, the receiver holds off once for a
    // long stretch so that the block fills up and has to stall its input.
    always @(posedge aclk) begin : monitor
        int stall_left;
        int hold_left;
        bit hold_done;
        bit take_next;
        row_result_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                retired_cnt <= retired_cnt + 1;
                if (expected_rows.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("ERROR: result with none expected: digits %h value %0d",
                                 m_packed_digits, m_binary_content);
                    end
                end else begin
                    want = expected_rows.pop_front();
                    if (m_packed_digits !== want.bcd || m_binary_content !== want.content) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("ERROR: result %0d: digits %h (want %h) value %0d (want %0d)",
                                     retired_cnt, m_packed_digits, want.bcd,
                                     m_binary_content, want.content);
                        end
                    end
                end
            end
            if (!hold_done && retired_cnt == HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                take_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                take_next = 1'b0;
            end else if (idling_allowed(retired_cnt) && $urandom_range(0, 4) == 0) begin
                // This cycle counts as the first of the stall; stall_left holds the rest.
                stall_left = $urandom_range(0, 2);
                take_next  = 1'b0;
            end else begin
                take_next = 1'b1;
            end
            m_ready <= take_next;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("FAIL decimal_digit_accumulator");
            $finish;
        end
    end

    initial begin : stimulus
        logic [VALUE_W-1:0] v;
        int                 roll;

        for (int k = 0; k < DIGITS; k++) begin
            row_digits[k] = '0;
        end

        // Directed part: subtract from an empty row, full-width operands that only
        // count by their low six decimal digits, wrap on add and on subtract, the
        // unused mode, set with zero and set with a value wider than the row.
        queue_op(MODE_SUB, VALUE_W'(5));
        queue_op(MODE_ADD, '1);
        queue_op(MODE_ADD, '0);
        queue_op(MODE_SUB, VALUE_W'(777215));
        queue_op(MODE_SUB, VALUE_W'(1));
        queue_op(MODE_SET, VALUE_W'(999999));
        queue_op(MODE_ADD, VALUE_W'(1));
        queue_op(MODE_SET, VALUE_W'(5));
        queue_op(MODE_SUB, VALUE_W'(7));
        queue_op(MODE_UNUSED, '1);
        queue_op(MODE_SET, '0);
        queue_op(MODE_UNUSED, '0);
        queue_op(MODE_SET, '1);
        queue_op(MODE_SUB, '1);
        queue_op(MODE_SET, VALUE_W'(123456));
        queue_op(MODE_SUB, '0);
        queue_op(MODE_ADD, VALUE_W'(999999));
        queue_op(MODE_SET, VALUE_W'(1000000));
        queue_op(MODE_ADD, VALUE_W'(24'hAAAAAA));
        queue_op(MODE_SUB, VALUE_W'(24'h555555));
        queue_op(MODE_SUB, VALUE_W'(999999));

        // Random part. Besides single random operations there are short sequences
        // that reach the interesting states on purpose: a set followed by a
        // subtract of the same value empties the row, and the next subtract then
        // hits the empty row; a set near the top followed by an add wraps around.
        while (pending_ops.size() < RANDOM_ITEMS + 21) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                v = pick_value();
                queue_op(MODE_SET, v);
                queue_op(MODE_SUB, v);
                queue_op(MODE_SUB, pick_value());
            end else if (roll == 1) begin
                queue_op(MODE_SET, VALUE_W'($urandom_range(999000, 999999)));
                queue_op(MODE_ADD, pick_value());
            end else begin
                queue_op(pick_mode(), pick_value());
            end
        end
        total_items = pending_ops.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every transaction has been taken, then until every result is
        // back, then a little longer to catch any stray result.
        while (pending_ops.size() > 0 || s_valid) @(posedge aclk);
        while (expected_rows.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && expected_rows.size() == 0) begin
            $display("PASS decimal_digit_accumulator");
        end else begin
            $display("FAIL decimal_digit_accumulator");
        end
        $finish;
    end

endmodule
